/* design/bolel_pkg.sv */
// shared constants, codes and cell control types for the ordered list engine
package bolel_pkg;

  localparam int unsigned CAPACITY_DEFAULT    = 32;
  localparam int unsigned VALUE_WIDTH_DEFAULT = 32;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT     = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_REMOVE     = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_POS   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     in_use;
  } cell_ctrl_t;

endpackage

/* design/bolel_if.sv */
// request and response channel interfaces of the ordered list engine
interface bolel_req_if import bolel_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink (input valid, input operation, input value, input position,
                output ready);
endinterface

interface bolel_rsp_if import bolel_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] removed_value;
  logic [COUNT_W-1:0]       entry_count;

  modport source (output valid, output status, output removed_value, output entry_count,
                  input ready);
  modport sink (input valid, input status, input removed_value, input entry_count,
                output ready);
endinterface

/* design/bolel_cell.sv */
// one storage cell of the list: holds, loads, or takes a neighbor's entry
module bolel_cell import bolel_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk_i,
  input  cell_ctrl_t             ctrl_i,
  input  logic [VALUE_WIDTH-1:0] load_value_i,
  input  logic [VALUE_WIDTH-1:0] left_value_i,
  input  logic [VALUE_WIDTH-1:0] right_value_i,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic                   match_o
);

  logic [VALUE_WIDTH-1:0] value_q, value_d;

  always_comb begin
    unique case (ctrl_i.op)
      CELL_HOLD:       value_d = value_q;
      CELL_LOAD:       value_d = load_value_i;
      CELL_FROM_LEFT:  value_d = left_value_i;
      CELL_FROM_RIGHT: value_d = right_value_i;
      default:         value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  // only entries below the count take part in a search
  assign match_o = ctrl_i.in_use && (value_q == load_value_i);

endmodule

/* design/bolel_find.sv */
// first-match search: marks every cell at or after the frontmost hit
module bolel_find import bolel_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
  input  logic [CAPACITY-1:0] match_i,
  output logic [CAPACITY-1:0] upto_o,
  output logic                found_o
);

  localparam int unsigned LEVELS = $clog2(CAPACITY);

  logic [CAPACITY-1:0] lvl [LEVELS+1];

  assign lvl[0] = match_i;

  // log-depth prefix or, each level spans twice the distance
  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    for (genvar i = 0; i < CAPACITY; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_merge
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1<<k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  assign upto_o  = lvl[LEVELS];
  assign found_o = lvl[LEVELS][CAPACITY-1];

endmodule

/* design/bounded_ordered_list_engine.sv */
// top level of the bounded ordered list engine
//
// usage:
//   req_i carries one request per handshake (valid and ready high at a
//   rising edge): an operation code, a value and an insert position.
//   rsp_o returns exactly one response per request: status, the value
//   taken by a pop, and the entry count after the operation.
//   the list lives in a row of CAPACITY cells; every cell decides in the
//   accept cycle whether it holds, loads the new value or takes its left
//   or right neighbor, so each request completes in the cycle it is taken.
//   the response is registered and is valid in the cycle after the request is accepted.
//   throughput: one request per cycle while responses are taken, set by the
//   single update of the cell row plus the first-match search in that cycle.
//   the response sits in an output register; req_i stays ready while that
//   register is empty or is being drained, so a stalled receiver holds the
//   response and blocks new requests until it takes it.
//   reset clears the count and the response valid; cell contents are not
//   cleared and are only ever read below the count.
module bounded_ordered_list_engine import bolel_pkg::*; #(
  parameter int unsigned CAPACITY    = CAPACITY_DEFAULT,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bolel_req_if.sink    req_i,
  bolel_rsp_if.source  rsp_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]       count_q, count_d;
  logic                   out_valid_q;
  status_e                status_q, status_d;
  logic [DATA_W-1:0]      removed_q, removed_d;
  logic [COUNT_W-1:0]     out_count_q;

  logic                   req_fire;
  logic [VALUE_WIDTH-1:0] in_value;
  logic [CMP_W-1:0]       count_ext;
  logic [CMP_W-1:0]       ins_idx;
  logic                   ins_bad;
  logic                   is_full;
  logic                   is_empty;
  logic [IDX_W-1:0]       tail_idx;
  logic                   do_insert;
  logic                   do_pop_front;
  logic                   do_remove;

  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]    cell_match;
  logic [CAPACITY-1:0]    match_upto;
  logic                   found;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  // sign-extend or truncate the request value to the cell width
  assign in_value  = VALUE_WIDTH'(req_i.value);
  assign count_ext = CMP_W'(count_q);
  assign is_full   = (count_q == CNT_W'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign tail_idx  = IDX_W'(count_q - 1'b1);

  always_comb begin
    unique case (req_i.operation) inside
      OP_PUSH_FRONT: ins_idx = '0;
      OP_PUSH_BACK:  ins_idx = count_ext;
      default:       ins_idx = CMP_W'(req_i.position);
    endcase
  end

  assign ins_bad = (ins_idx > count_ext);

  always_comb begin
    do_insert    = 1'b0;
    do_pop_front = 1'b0;
    do_remove    = 1'b0;
    status_d     = ST_DONE;
    removed_d    = '0;
    count_d      = count_q;
    unique case (req_i.operation) inside
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
        // position check wins over the full check
        if (ins_bad) begin
          status_d = ST_BAD_POS;
        end else if (is_full) begin
          status_d = ST_FULL;
        end else begin
          do_insert = 1'b1;
          count_d   = count_q + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          do_pop_front = 1'b1;
          removed_d    = DATA_W'(cell_val[0]);
          count_d      = count_q - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          removed_d = DATA_W'(cell_val[tail_idx]);
          count_d   = count_q - 1'b1;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          do_remove = 1'b1;
          count_d   = count_q - 1'b1;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMP_W-1:0] CellIdx = CMP_W'(i);

    cell_ctrl_t             ctrl;
    logic [VALUE_WIDTH-1:0] left_val;
    logic [VALUE_WIDTH-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_left
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_right
      assign right_val = cell_val[i+1];
    end

    always_comb begin
      ctrl.in_use = (CellIdx < count_ext);
      ctrl.op     = CELL_HOLD;
      if (req_fire) begin
        if (do_insert) begin
          if (CellIdx == ins_idx) begin
            ctrl.op = CELL_LOAD;
          end else if (CellIdx > ins_idx) begin
            ctrl.op = CELL_FROM_LEFT;
          end
        end else if (do_pop_front) begin
          ctrl.op = CELL_FROM_RIGHT;
        end else if (do_remove && match_upto[i]) begin
          // close the gap from the first hit onward
          ctrl.op = CELL_FROM_RIGHT;
        end
      end
    end

    bolel_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .load_value_i  (in_value),
      .left_value_i  (left_val),
      .right_value_i (right_val),
      .value_o       (cell_val[i]),
      .match_o       (cell_match[i])
    );
  end

  bolel_find #(
    .CAPACITY (CAPACITY)
  ) u_find (
    .match_i (cell_match),
    .upto_o  (match_upto),
    .found_o (found)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      status_q    <= status_d;
      removed_q   <= removed_d;
      out_count_q <= COUNT_W'(count_d);
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.removed_value = removed_q;
  assign rsp_o.entry_count   = out_count_q;

endmodule

/* design/bolel_checker.sv */
// port-level checks for the ordered list engine, bound to the top level
module bolel_checker import bolel_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] rsp_status_i,
  input logic [DATA_W-1:0]   rsp_removed_i,
  input logic [COUNT_W-1:0]  rsp_count_i
);

  // every accepted request shows its response in the next cycle
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> rsp_valid_i)
    else $error("response missing after accepted request");

  // a stalled response keeps its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_removed_i)
       && $stable(rsp_count_i)))
    else $error("stalled response changed");

  // an empty rejection reports no entries and no removed value
  a_empty_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_status_i == ST_EMPTY) |->
      (rsp_count_i == '0 && rsp_removed_i == '0))
    else $error("empty status with entries or data");

  // a full rejection leaves the list at capacity
  a_full_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_status_i == ST_FULL) |->
      (rsp_count_i == COUNT_W'(CAPACITY) && rsp_removed_i == '0))
    else $error("full status below capacity");

endmodule

bind bounded_ordered_list_engine bolel_checker #(
  .CAPACITY (CAPACITY)
) u_bolel_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_removed_i (rsp_o.removed_value),
  .rsp_count_i   (rsp_o.entry_count)
);
